// ===== rtl/core/psched_pkg.sv =====
package psched_pkg;

  localparam int NUM_THREADS_DEF   = 32;
  localparam int TIMEOUT_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int PRIO_W  = 6;
  localparam int TICKS_W = 32;
  localparam int ERR_W   = 2;
  localparam int MASK_W  = 32;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 48;

  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELAY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCHED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DONE  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PRIO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_IDLE = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ZERO = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic exec;       // apply start, delay or switch done
    logic walk_clr;   // restart the timeout walk
    logic walk_step;  // advance the timeout walk by one entry
    logic sched;      // pick the highest ready priority
    logic load_out;   // load the result register
  } psched_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic             delay_ok;
    logic             walk_done;
    logic             out_free;
  } psched_stat_t;

endpackage

// ===== rtl/core/psched_ctrl.sv =====
module psched_ctrl
  import psched_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  psched_stat_t stat,
  output psched_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SCHED,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.code)
          CMD_TICK: begin
            cmd.walk_clr = 1'b1;
            state_nxt    = S_WALK;
          end
          CMD_DELAY: state_nxt = stat.delay_ok ? S_SCHED : S_OUT;
          CMD_SCHED: state_nxt = S_SCHED;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_OUT;
        end
      end
      S_SCHED: begin
        cmd.sched = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/psched_dp.sv =====
module psched_dp
  import psched_pkg::*;
#(
  parameter int NUM_THREADS   = NUM_THREADS_DEF,
  parameter int TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  psched_cmd_t      cmd,
  output psched_stat_t     stat
);

  localparam int AW = $clog2(NUM_THREADS);
  localparam int CW = $clog2(NUM_THREADS + 1);

  logic [CMD_W-1:0]         code_r;
  logic [PRIO_W-1:0]        prio_r;
  logic [TIMEOUT_WIDTH-1:0] ticks_r;

  logic [NUM_THREADS-1:0] ready_r, ready_nxt;
  logic [NUM_THREADS-1:0] delayed_r, delayed_nxt;
  logic [NUM_THREADS:0]   started_r, started_nxt;
  logic [PRIO_W-1:0]      current_r, current_nxt;
  logic [PRIO_W-1:0]      chosen_r, chosen_nxt;
  logic [ERR_W-1:0]       err_r, err_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;

  logic [TIMEOUT_WIDTH-1:0] mem [NUM_THREADS];
  logic [TIMEOUT_WIDTH-1:0] rd_data_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [TIMEOUT_WIDTH-1:0] mem_wdata;
  logic                     mem_rd;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic [PRIO_W-1:0]        prio_m1;
  logic [PRIO_W-1:0]        cur_m1;
  logic [CW-1:0]            idx_m1;
  logic [TIMEOUT_WIDTH-1:0] dec_val;
  logic                     cur_valid;

  function automatic logic [PRIO_W-1:0] top_prio(input logic [NUM_THREADS-1:0] bits);
    logic [PRIO_W-1:0] p;
    p = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (bits[i]) begin
        p = PRIO_W'(i + 1);
      end
    end
    return p;
  endfunction

  assign prio_m1   = prio_r - PRIO_W'(1);
  assign cur_m1    = current_r - PRIO_W'(1);
  assign idx_m1    = idx_r - CW'(1);
  assign dec_val   = rd_data_r - TIMEOUT_WIDTH'(1);
  assign cur_valid = (current_r != '0) && (current_r <= PRIO_W'(NUM_THREADS));

  assign stat.code      = code_r;
  assign stat.delay_ok  = cur_valid && (ticks_r != '0);
  assign stat.walk_done = (idx_r == CW'(NUM_THREADS));
  assign stat.out_free  = !out_valid_r || out_tready;

  assign mem_rd = cmd.walk_step && (idx_r < CW'(NUM_THREADS));

  always_comb begin
    ready_nxt   = ready_r;
    delayed_nxt = delayed_r;
    started_nxt = started_r;
    current_nxt = current_r;
    chosen_nxt  = chosen_r;
    err_nxt     = err_r;
    idx_nxt     = idx_r;
    mem_we      = 1'b0;
    mem_waddr   = cur_m1[AW-1:0];
    mem_wdata   = ticks_r;

    if (cmd.exec) begin
      err_nxt = ERR_OK;
      case (code_r)
        CMD_START: begin
          if (prio_r > PRIO_W'(NUM_THREADS)) begin
            err_nxt = ERR_PRIO;
          end else if (started_r[prio_r[CW-1:0]]) begin
            err_nxt = ERR_PRIO;
          end else begin
            started_nxt[prio_r[CW-1:0]] = 1'b1;
            if (prio_r != '0) begin
              ready_nxt[prio_m1[AW-1:0]] = 1'b1;
            end
          end
        end
        CMD_DELAY: begin
          if (!cur_valid) begin
            err_nxt = ERR_IDLE;
          end else if (ticks_r == '0) begin
            err_nxt = ERR_ZERO;
          end else begin
            mem_we                      = 1'b1;
            ready_nxt[cur_m1[AW-1:0]]   = 1'b0;
            delayed_nxt[cur_m1[AW-1:0]] = 1'b1;
          end
        end
        CMD_DONE: current_nxt = chosen_r;
        default: ;
      endcase
    end

    if (cmd.walk_clr) begin
      idx_nxt = '0;
    end

    // The entry read in the previous cycle is decremented and written back
    // while the next entry is being read.
    if (cmd.walk_step) begin
      if (idx_r != '0 && delayed_r[idx_m1[AW-1:0]]) begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[AW-1:0];
        mem_wdata = dec_val;
        if (dec_val == '0) begin
          ready_nxt[idx_m1[AW-1:0]]   = 1'b1;
          delayed_nxt[idx_m1[AW-1:0]] = 1'b0;
        end
      end
      if (idx_r != CW'(NUM_THREADS)) begin
        idx_nxt = idx_r + CW'(1);
      end
    end

    if (cmd.sched) begin
      chosen_nxt = top_prio(ready_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= '0;
      delayed_r   <= '0;
      started_r   <= '0;
      current_r   <= '0;
      chosen_r    <= '0;
      err_r       <= ERR_OK;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ready_r   <= ready_nxt;
      delayed_r <= delayed_nxt;
      started_r <= started_nxt;
      current_r <= current_nxt;
      chosen_r  <= chosen_nxt;
      err_r     <= err_nxt;
      idx_r     <= idx_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r  <= in_tdata[CMD_W-1:0];
      prio_r  <= in_tdata[CMD_W +: PRIO_W];
      ticks_r <= in_tdata[CMD_W+PRIO_W +: TIMEOUT_WIDTH];
    end
    if (cmd.load_out) begin
      out_data_r <= {(OUT_W - MASK_W - ERR_W - 1 - PRIO_W)'(0), MASK_W'(ready_r), err_r,
                     (chosen_r != current_r), chosen_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/priority_thread_scheduler.sv =====
// Priority thread scheduler for up to NUM_THREADS prioritized threads plus an
// idle thread at priority 0.
// The in_ channel carries one command per transaction; each command returns
// exactly one result transaction on the out_ channel with the chosen thread,
// a switch-wanted flag, an error code and the ready mask after the command.
// Commands are handled one at a time. After the accepting edge a command is
// executed in S_EXEC; start, switch done, a rejected delay and unknown codes
// then go straight to S_OUT, schedule and a successful delay pass through
// S_SCHED first, and a tick passes through S_WALK, because a tick walks the
// timeout memory one entry per cycle through its single read port.
// The result is loaded into the output register from S_OUT, and in_tready
// rises in the same cycle as out_tvalid.
// in_tready is high only while no command is in progress; a new command may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the result is held and the next command stops at
// the output register until the result is taken.
// Reset clears all thread state and the output valid flag; the timeout memory
// is not cleared, since an entry is only used after it was written by a delay.
module priority_thread_scheduler
  import psched_pkg::*;
#(
  parameter int NUM_THREADS   = NUM_THREADS_DEF,
  parameter int TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[2:0], priority_req[8:3], delay_ticks[40:9]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // next_thread[5:0], switch_request[6],
                                       // error_code[8:7], ready_mask[40:9]
);

  psched_cmd_t  cmd;
  psched_stat_t stat;

  psched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psched_dp #(
    .NUM_THREADS   (NUM_THREADS),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

  logic [PRIO_W-1:0] out_next;
  logic [MASK_W-1:0] out_mask;

  assign out_next = out_tdata[PRIO_W-1:0];
  assign out_mask = out_tdata[PRIO_W+1+ERR_W +: MASK_W];

  // Only one command is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in progress");

  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_next <= PRIO_W'(NUM_THREADS))
    else $error("chosen thread beyond the thread count");

  // Ready bits are cleared only by a delay, which reschedules right away.
  a_chosen_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_next != '0 |->
      ((out_mask >> (out_next - PRIO_W'(1))) & MASK_W'(1)) != '0)
    else $error("chosen thread is not ready");

  a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.exec)
    else $error("captured command was not executed");

endmodule
